// ===== rtl/core/apa_pkg.sv =====
// Package for the access profiled array: sizes, request codes, payload structs and
// the sequencer state type. Depends on nothing; all modules but apa_ram import it.
package apa_pkg;

  localparam int DEPTH      = 64;
  localparam int COUNT_BITS = 24;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CFG_W      = 7;
  localparam int VALUE_W    = 32;
  localparam int TOTAL_W    = 30;
  localparam int SQ_W       = 54;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int VAR_W      = 61;
  localparam int Q_SPLIT    = 27;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(64);

  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_REPORT = 2'd2;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [IDX_W-1:0]          position;
    logic signed [VALUE_W-1:0] write_value;
  } apa_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_BITS-1:0]     access_count;
    logic [IDX_W-1:0]          hot_index;
    logic                      hot_valid;
    logic [TOTAL_W-1:0]        total_accesses;
    logic                      contents_sorted;
    logic                      last;
  } apa_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_P1_RD,
    ST_P1_EX,
    ST_P1_FIN,
    ST_V0,
    ST_V1,
    ST_V2,
    ST_V3,
    ST_P2_RD,
    ST_P2_MUL,
    ST_P2_SQ,
    ST_P2_CMP,
    ST_P2_END
  } apa_st_e;

endpackage

// ===== rtl/core/apa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the entry data and the access counters.
module apa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/access_profiled_array.sv =====
// Top level of the access profiled array: request sequencer, shared multiplier and
// result register. Depends on apa_pkg and instantiates apa_ram twice.
//
// The block is a store of 64 signed 32-bit words that counts accesses per entry.
// A read or a write of an entry bumps its 24-bit access count (saturating at the
// maximum) and returns one result with the data after the access and the new
// count; a position at or beyond entries_in_use changes nothing and returns a
// result that carries only total_accesses and last. A report walks the entries
// in use twice: the first walk forms the count sum S, the sum of squared counts Q
// and the sorted flag, then N*Q - S*S is formed, and the second walk streams, in
// rising index order, every entry with N*c - S >= 0 and (N*c - S)^2 >= N*Q - S*S.
// A report with no such entry returns a single result with hot_valid low. The
// final result of every request has last set. Request code 3 is taken and
// dropped without a result. One request is in flight at a time. A read or write
// goes through ST_ACC_RD and ST_ACC_WR, which loads its result into the output
// register; a report reads each entry in ST_P1_RD and ST_P1_EX in the first walk
// and in ST_P2_RD, ST_P2_MUL, ST_P2_SQ and ST_P2_CMP in the second, because every
// product goes through the one 32x32 multiplier and every entry through the one
// read port of the counter and data memories. A full output register that is not
// taken stalls ST_ACC_WR, ST_P2_CMP and ST_P2_END while a result is due. Reset
// clears the per-entry valid bits at once, so no clearing pass runs and the
// block is ready as soon as reset is released. Writes to entries_in_use are
// taken at any time and are meant to arrive while the block is idle; 0 acts as
// 1 and values above 64 act as 64.
module access_profiled_array
  import apa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  apa_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output apa_out_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // Sequencer state and the latched request.
  apa_st_e                   st_q, st_d;
  logic [1:0]                req_q;
  logic [IDX_W-1:0]          pos_q;
  logic signed [VALUE_W-1:0] wval_q;
  logic                      oor_q;

  // Configuration and the effective number of entries in use.
  logic [CFG_W-1:0]          cfg_q;
  logic [CFG_W-1:0]          n_eff;

  // Per-entry valid bits: an entry that was never written reads as zero.
  logic [DEPTH-1:0]          valid_q;
  logic                      rd_vld_q;

  // Running total of all access counts, as seen on every result.
  logic [TOTAL_W-1:0]        sum_q;

  // Report walk state.
  logic [CFG_W-1:0]          idx_q;
  logic [TOTAL_W-1:0]        s_q;
  logic [SQ_W-1:0]           q_q;
  logic signed [VALUE_W-1:0] prev_q;
  logic                      sorted_q;
  logic [VAR_W-1:0]          nq_q;
  logic [VAR_W-1:0]          var_q;
  logic                      ge_q;
  logic [COUNT_BITS-1:0]     c_q;
  logic                      pend_q;
  logic [IDX_W-1:0]          pend_idx_q;
  logic [COUNT_BITS-1:0]     pend_cnt_q;

  // Shared multiplier with its product register.
  logic [MUL_W-1:0]          mul_a, mul_b;
  logic                      mul_en;
  logic [PROD_W-1:0]         prod_q;

  // Memory ports.
  logic                      ram_re, ram_we;
  logic [IDX_W-1:0]          ram_raddr;
  logic [COUNT_BITS-1:0]     cnt_rdata;
  logic [VALUE_W-1:0]        val_rdata;
  logic [COUNT_BITS-1:0]     cnt_wdata;
  logic signed [VALUE_W-1:0] val_wdata;

  // Result register.
  logic                      out_valid_q;
  apa_out_t                  out_q;
  logic                      out_free;
  logic                      push;
  apa_out_t                  push_data;

  // Datapath values derived from the read data.
  logic [COUNT_BITS-1:0]     c_rd;
  logic signed [VALUE_W-1:0] v_rd;
  logic                      c_sat;
  logic [TOTAL_W-1:0]        nc;
  logic [TOTAL_W-1:0]        dev;
  logic                      hot;
  logic                      walk_end;

  assign n_eff = (cfg_q == '0) ? CFG_W'(1) :
                 (cfg_q > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : cfg_q;

  assign c_rd      = rd_vld_q ? cnt_rdata : '0;
  assign v_rd      = rd_vld_q ? $signed(val_rdata) : '0;
  assign c_sat     = (c_rd == COUNT_MAX);
  assign cnt_wdata = c_sat ? c_rd : c_rd + COUNT_BITS'(1);
  assign val_wdata = (req_q == REQ_WRITE) ? wval_q : v_rd;

  assign nc       = prod_q[TOTAL_W-1:0];
  assign dev      = nc - s_q;
  assign hot      = ge_q && (prod_q[VAR_W-1:0] >= var_q);
  assign walk_end = (idx_q + CFG_W'(1) == n_eff);

  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Memories: entry data and access counters share the address of each step.
  apa_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(val_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(val_rdata)
  );

  apa_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(DEPTH)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(cnt_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(cnt_rdata)
  );

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Next state, memory control, multiplier operands and result pushes.
  always_comb begin
    st_d       = st_q;
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = idx_q[IDX_W-1:0];
    mul_a      = '0;
    mul_b      = '0;
    mul_en     = 1'b0;
    push       = 1'b0;
    push_data  = '0;
    push_data.total_accesses = sum_q;

    unique case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_data_i.req_type) inside
            REQ_READ, REQ_WRITE: st_d = ST_ACC_RD;
            REQ_REPORT:          st_d = ST_P1_RD;
            default:             st_d = ST_IDLE;
          endcase
        end
      end
      ST_ACC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_q;
        st_d      = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        if (out_free) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          if (!oor_q) begin
            ram_we                 = 1'b1;
            push_data.read_value   = val_wdata;
            push_data.access_count = cnt_wdata;
            if (!c_sat) begin
              push_data.total_accesses = sum_q + TOTAL_W'(1);
            end
          end
          st_d = ST_IDLE;
        end
      end
      ST_P1_RD: begin
        ram_re = 1'b1;
        st_d   = ST_P1_EX;
      end
      ST_P1_EX: begin
        mul_a  = MUL_W'(c_rd);
        mul_b  = MUL_W'(c_rd);
        mul_en = 1'b1;
        st_d   = walk_end ? ST_P1_FIN : ST_P1_RD;
      end
      ST_P1_FIN: begin
        st_d = ST_V0;
      end
      ST_V0: begin
        mul_a  = MUL_W'(n_eff);
        mul_b  = MUL_W'(q_q[Q_SPLIT-1:0]);
        mul_en = 1'b1;
        st_d   = ST_V1;
      end
      ST_V1: begin
        mul_a  = MUL_W'(n_eff);
        mul_b  = MUL_W'(q_q[SQ_W-1:Q_SPLIT]);
        mul_en = 1'b1;
        st_d   = ST_V2;
      end
      ST_V2: begin
        mul_a  = MUL_W'(s_q);
        mul_b  = MUL_W'(s_q);
        mul_en = 1'b1;
        st_d   = ST_V3;
      end
      ST_V3: begin
        st_d = ST_P2_RD;
      end
      ST_P2_RD: begin
        ram_re = 1'b1;
        st_d   = ST_P2_MUL;
      end
      ST_P2_MUL: begin
        mul_a  = MUL_W'(n_eff);
        mul_b  = MUL_W'(c_rd);
        mul_en = 1'b1;
        st_d   = ST_P2_SQ;
      end
      ST_P2_SQ: begin
        mul_a  = MUL_W'(dev);
        mul_b  = MUL_W'(dev);
        mul_en = 1'b1;
        st_d   = ST_P2_CMP;
      end
      ST_P2_CMP: begin
        // A new hot entry displaces the held one, which then goes out.
        if (!(hot && pend_q && !out_free)) begin
          if (hot && pend_q) begin
            push                      = 1'b1;
            push_data.access_count    = pend_cnt_q;
            push_data.hot_index       = pend_idx_q;
            push_data.hot_valid       = 1'b1;
            push_data.contents_sorted = sorted_q;
          end
          st_d = walk_end ? ST_P2_END : ST_P2_RD;
        end
      end
      ST_P2_END: begin
        if (out_free) begin
          push                      = 1'b1;
          push_data.contents_sorted = sorted_q;
          push_data.last            = 1'b1;
          if (pend_q) begin
            push_data.access_count = pend_cnt_q;
            push_data.hot_index    = pend_idx_q;
            push_data.hot_valid    = 1'b1;
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Control registers: configuration, valid bits, total, result register, walk state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      valid_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if (ram_we) begin
        valid_q[pos_q] <= 1'b1;
        if (!c_sat) begin
          sum_q <= sum_q + TOTAL_W'(1);
        end
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q) inside
        ST_IDLE: begin
          idx_q  <= '0;
          pend_q <= 1'b0;
        end
        ST_P1_EX, ST_P2_CMP: begin
          if (st_d != st_q) begin
            idx_q <= walk_end ? '0 : idx_q + CFG_W'(1);
          end
          if (st_q == ST_P2_CMP && st_d != st_q && hot) begin
            pend_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and arithmetic registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q  <= in_data_i.req_type;
      pos_q  <= in_data_i.position;
      wval_q <= in_data_i.write_value;
      oor_q  <= ({1'b0, in_data_i.position} >= n_eff);
      s_q      <= '0;
      q_q      <= '0;
      sorted_q <= 1'b1;
    end
    if (ram_re) begin
      rd_vld_q <= valid_q[ram_raddr];
    end
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (push) begin
      out_q <= push_data;
    end
    case (st_q)
      ST_P1_RD: begin
        // The square of the previous entry is still in the product register.
        if (idx_q != '0) begin
          q_q <= q_q + SQ_W'(prod_q[2*COUNT_BITS-1:0]);
        end
      end
      ST_P1_EX: begin
        s_q    <= s_q + TOTAL_W'(c_rd);
        prev_q <= v_rd;
        if (idx_q != '0 && prev_q > v_rd) begin
          sorted_q <= 1'b0;
        end
      end
      ST_P1_FIN: q_q <= q_q + SQ_W'(prod_q[2*COUNT_BITS-1:0]);
      ST_V1:     nq_q <= prod_q[VAR_W-1:0];
      ST_V2:     nq_q <= nq_q + {prod_q[VAR_W-Q_SPLIT-1:0], {Q_SPLIT{1'b0}}};
      ST_V3:     var_q <= nq_q - prod_q[VAR_W-1:0];
      ST_P2_MUL: c_q <= c_rd;
      ST_P2_SQ:  ge_q <= (nc >= s_q);
      ST_P2_CMP: begin
        if (st_d != st_q && hot) begin
          pend_idx_q <= idx_q[IDX_W-1:0];
          pend_cnt_q <= c_q;
        end
      end
      default: ;
    endcase
  end

  // The total moves by at most one per cycle, and only on a counted access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q == $past(sum_q) || (sum_q == $past(sum_q) + TOTAL_W'(1) && $past(ram_we)))
    else $error("total access count moved without a counted access");

  // A walk never addresses an entry beyond those in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_P1_RD || st_q == ST_P2_RD) |-> idx_q < n_eff)
    else $error("report walk index beyond entries in use");

  // N*Q can never fall below S*S, so the variance term is never negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_V3 |-> nq_q >= prod_q[VAR_W-1:0])
    else $error("negative variance term in report");

  // A result is never pushed into a full output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result pushed while output register full");

endmodule

// ===== test/apa_result_checker.sv =====
// Result checker for the access profiled array: watches the request, result and
// configuration channels, forecasts each result and compares it field by field.
// Depends on apa_pkg for the payload structs, sizes and request codes.
module apa_result_checker
  import apa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  apa_in_t          in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  apa_out_t         out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int unsigned      pending_o,
  output int unsigned      failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Wide enough for N*Q and S*S without any loss.
  typedef logic [127:0] wide_t;

  logic signed [VALUE_W-1:0] word_mem [DEPTH];
  logic [COUNT_BITS-1:0]     hit_count [DEPTH];
  logic [30:0]               hit_total;
  logic [CFG_W-1:0]          span_cfg;
  apa_out_t                  due_results [$];
  int unsigned               failures = 0;
  int unsigned               pending = 0;

  assign failures_o = failures;
  assign pending_o  = pending;

  function automatic int unsigned entries_active();
    if (span_cfg == '0) return 1;
    if (span_cfg > DEPTH) return DEPTH;
    return int'(span_cfg);
  endfunction

  task automatic note_failure(string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    failures++;
  endtask

  task automatic forecast_results(apa_in_t item);
    apa_out_t    res;
    apa_out_t    held;
    bit          have_held;
    int unsigned n;
    wide_t       s;
    wide_t       q;
    wide_t       spread;
    wide_t       d;
    logic        ascending;
    n   = entries_active();
    res = '0;
    if (item.req_type == REQ_READ || item.req_type == REQ_WRITE) begin
      if (int'(item.position) < int'(n)) begin
        if (item.req_type == REQ_WRITE) word_mem[item.position] = item.write_value;
        if (hit_count[item.position] != COUNT_MAX) begin
          hit_count[item.position] = hit_count[item.position] + 1'b1;
          hit_total = hit_total + 1'b1;
        end
        res.read_value   = word_mem[item.position];
        res.access_count = hit_count[item.position];
      end
      res.total_accesses = hit_total[TOTAL_W-1:0];
      res.last           = 1'b1;
      due_results.push_back(res);
    end else if (item.req_type == REQ_REPORT) begin
      s         = '0;
      q         = '0;
      ascending = 1'b1;
      have_held = 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
        s += wide_t'(hit_count[i]);
        q += wide_t'(hit_count[i]) * wide_t'(hit_count[i]);
        if (i + 1 < n && word_mem[i] > word_mem[i + 1]) ascending = 1'b0;
      end
      spread              = wide_t'(n) * q - s * s;
      res.total_accesses  = hit_total[TOTAL_W-1:0];
      res.contents_sorted = ascending;
      // Hold back each hot entry until the next one is found, so the final one
      // can carry last.
      for (int unsigned i = 0; i < n; i++) begin
        d = wide_t'(n) * wide_t'(hit_count[i]);
        if (d >= s && (d - s) * (d - s) >= spread) begin
          if (have_held) due_results.push_back(held);
          held              = res;
          held.access_count = hit_count[i];
          held.hot_index    = IDX_W'(i);
          held.hot_valid    = 1'b1;
          have_held         = 1'b1;
        end
      end
      if (!have_held) held = res;
      held.last = 1'b1;
      due_results.push_back(held);
    end
  endtask

  task automatic check_result(apa_out_t got);
    apa_out_t want;
    if (due_results.size() == 0) begin
      note_failure($sformatf("result %h arrived with nothing expected", got));
      return;
    end
    want = due_results.pop_front();
    if (got.read_value !== want.read_value)
      note_failure($sformatf("read_value %0d, expected %0d", got.read_value, want.read_value));
    if (got.access_count !== want.access_count)
      note_failure($sformatf("access_count %0d, expected %0d",
                             got.access_count, want.access_count));
    if (got.hot_index !== want.hot_index)
      note_failure($sformatf("hot_index %0d, expected %0d", got.hot_index, want.hot_index));
    if (got.hot_valid !== want.hot_valid)
      note_failure($sformatf("hot_valid %b, expected %b", got.hot_valid, want.hot_valid));
    if (got.total_accesses !== want.total_accesses)
      note_failure($sformatf("total_accesses %0d, expected %0d",
                             got.total_accesses, want.total_accesses));
    if (got.contents_sorted !== want.contents_sorted)
      note_failure($sformatf("contents_sorted %b, expected %b",
                             got.contents_sorted, want.contents_sorted));
    if (got.last !== want.last)
      note_failure($sformatf("last %b, expected %b", got.last, want.last));
  endtask

  // Results are compared before the request of the same edge is forecast; a
  // request can never produce its result in the cycle it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        word_mem[i]  = '0;
        hit_count[i] = '0;
      end
      hit_total = '0;
      span_cfg  = CFG_RESET;
      due_results.delete();
      pending = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (cfg_valid_i && cfg_ready_i) span_cfg = cfg_data_i;
      if (in_valid_i && in_ready_i) forecast_results(in_data_i);
      pending = due_results.size();
    end
  end

endmodule

// ===== test/access_profiled_array_test.sv =====
// Top level of the access profiled array testbench: clock, reset, request and
// configuration stimulus, result back-pressure, watchdog and verdict.
// Depends on apa_pkg, access_profiled_array and apa_result_checker.
module access_profiled_array_test;
  timeunit 1ns;
  timeprecision 1ps;
  import apa_pkg::*;

  // The request code that the block takes and drops without a result.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // The receiver's long hold-off, in cycles. It has to outlast the time the
  // block needs to fill its output register and stop taking requests.
  localparam int unsigned HOLD_CYCLES = 400;

  // Cycles allowed after the last expected result before the block counts as
  // idle. An access ends in ST_ACC_WR after ST_ACC_RD, and a dropped request
  // never leaves ST_IDLE.
  localparam int unsigned SETTLE_CYCLES = 24;

  // A full-size report walks all 64 entries twice and may make no transfer until
  // its end, and the long hold-off can sit on top of one; this limit lies well above both.
  localparam int unsigned STALL_LIMIT = 4000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  apa_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  apa_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  int unsigned pending;
  int unsigned failures;

  // Entries in use as the block sees them, after clamping of the register.
  int unsigned span;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req;

  // With steady set the sender offers requests back to back; otherwise it
  // works in bursts of random length separated by random gaps.
  bit          steady;
  int unsigned burst_left;
  int unsigned quiet_cycles;

  access_profiled_array u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  apa_result_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .failures_o  (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic apa_in_t request(logic [1:0] kind, int unsigned pos,
                                      logic [VALUE_W-1:0] value);
    apa_in_t item;
    item.req_type    = kind;
    item.position    = IDX_W'(pos);
    item.write_value = value;
    return item;
  endfunction

  // Data words lean toward the signed extremes and small values near zero,
  // where ordering mistakes in the sorted flag tend to show up.
  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return VALUE_W'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  function automatic apa_in_t random_request();
    int unsigned roll;
    int unsigned pos;
    logic [1:0]  kind;
    roll = $urandom_range(0, 99);
    if (roll < 40) kind = REQ_READ;
    else if (roll < 75) kind = REQ_WRITE;
    else if (roll < 92) kind = REQ_REPORT;
    else kind = REQ_UNUSED;
    case ($urandom_range(0, 9))
      // Any position at all, often one beyond the entries in use.
      0: pos = $urandom_range(0, DEPTH - 1);
      // Entry 0 is favored so that the count profile gets skewed and reports
      // pick out a few hot entries rather than all of them.
      1, 2: pos = 0;
      default: pos = $urandom_range(0, span - 1);
    endcase
    return request(kind, pos, random_word());
  endfunction

  // Lower valid for a number of cycles. Called only right after a transfer,
  // so valid never drops while an item is still on offer.
  task automatic rest_input(int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Put one request on the channel and hold it until the transfer. Valid is
  // raised once per item, so back-to-back items keep it high without a dip.
  task automatic offer(apa_in_t item);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (!steady) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        rest_input($urandom_range(1, 6));
        burst_left = $urandom_range(1, 10);
      end
    end
  endtask

  // Stop offering and wait until every forecast result has been taken, then
  // give the block time to finish any request that makes no result.
  task automatic wait_drained();
    rest_input(0);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes happen only with the block drained.
  task automatic set_entries(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    span = (value == '0) ? 1 : ((value > DEPTH) ? DEPTH : int'(value));
  endtask

  // Write the entries in use in non-decreasing order, with equal neighbors
  // now and then, so that reports see the sorted flag set.
  task automatic fill_ascending();
    logic [VALUE_W-1:0] level;
    level = 32'h8000_0000 + VALUE_W'($urandom_range(0, 1000));
    for (int unsigned i = 0; i < span; i++) begin
      offer(request(REQ_WRITE, i, level));
      level = level + VALUE_W'($urandom_range(0, 3));
    end
  endtask

  // Receiver: picks a stall pattern for a window of random length, from
  // always ready to mostly stalled. A hold-off request takes priority.
  initial begin : receiver
    int unsigned mode;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        repeat ($urandom_range(8, 40)) begin
          @(negedge clk);
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ~out_ready;
          endcase
        end
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on any channel for too long.
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] settings [8];
    settings   = '{7'd3, 7'd1, 7'd8, 7'd0, 7'd5, 7'd127, 7'd2, 7'd64};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    span       = DEPTH;
    steady     = 1'b1;
    burst_left = 1;
    hold_req   = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, first with the register at its reset value. A report on
    // the fresh store sees all counts equal, so every entry comes out hot and
    // the block streams its largest possible number of results.
    offer(request(REQ_REPORT, 0, '0));
    offer(request(REQ_READ, 0, '0));
    offer(request(REQ_WRITE, 0, 32'h8000_0000));
    offer(request(REQ_WRITE, 1, 32'hFFFF_FFFF));
    offer(request(REQ_WRITE, DEPTH - 1, 32'h7FFF_FFFF));
    // Contents are still ascending here; the position and data fields of a
    // report carry junk that the block must ignore.
    offer(request(REQ_REPORT, DEPTH - 1, 32'hFFFF_FFFF));
    // A -5 at entry 2 sits below the -1 at entry 1 and breaks the order.
    offer(request(REQ_WRITE, 2, 32'hFFFF_FFFB));
    offer(request(REQ_UNUSED, 5, 32'h1234_5678));
    offer(request(REQ_READ, DEPTH - 1, '0));
    offer(request(REQ_REPORT, 0, '0));

    // Zero entries in use behaves as one: position 1 and up are out of range,
    // and an out-of-range write must leave the entry alone.
    wait_drained();
    set_entries(7'd0);
    offer(request(REQ_READ, 0, '0));
    offer(request(REQ_READ, 1, '0));
    offer(request(REQ_WRITE, DEPTH - 1, 32'h5555_AAAA));
    offer(request(REQ_REPORT, 0, '0));

    // All register bits set clamps to the full depth; entry 63 still holds
    // the maximum word.
    wait_drained();
    set_entries(7'd127);
    offer(request(REQ_READ, DEPTH - 1, '0));
    offer(request(REQ_REPORT, 0, '0));

    // Two entries with equal data and counts left over from earlier phases.
    wait_drained();
    set_entries(7'd2);
    offer(request(REQ_WRITE, 0, 32'd5));
    offer(request(REQ_WRITE, 1, 32'd5));
    offer(request(REQ_READ, 1, '0));
    offer(request(REQ_REPORT, 0, '0));

    // Random part: one register setting per phase, drained in between, so
    // counts left from a larger setting meet reports over a smaller one.
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      set_entries(settings[phase]);
      steady = (phase % 4 == 1);
      if (span <= 8 && $urandom_range(0, 1) == 1) fill_ascending();
      if (phase == 2) begin
        // The receiver holds off while the sender keeps offering, so the
        // block fills up and stops taking requests for a while.
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++) offer(request(REQ_READ, $urandom_range(0, span - 1), '0));
      end
      for (int k = 0; k < 22; k++) offer(random_request());
    end

    wait_drained();
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/apa_pkg.sv
rtl/core/apa_ram.sv
rtl/core/access_profiled_array.sv
test/apa_result_checker.sv
test/access_profiled_array_test.sv
